// File: rtl/gts_pkg.sv
// Shared constants, codes and helpers for the two-reaction Gillespie stepper.
`timescale 1ns / 1ps
`default_nettype none
package gts_pkg;

    localparam int COUNT_BITS     = 16;
    localparam int TIME_BITS      = 48;
    localparam int TIME_FRAC_BITS = 24;
    localparam int RAND_BITS      = 32;
    localparam int RATE_BITS      = 32;
    localparam int RATE_FRAC      = 24;
    localparam int PROP_BITS      = 64;

    localparam int DIG_BITS   = 8;
    localparam int MUL_DIGITS = 5;
    localparam int MP_BITS    = DIG_BITS * MUL_DIGITS;
    localparam int MC_BITS    = PROP_BITS;
    localparam int ACC_BITS   = MC_BITS + MP_BITS;
    localparam int MCNT_BITS  = $clog2(MUL_DIGITS + 1);

    localparam int E_BITS     = 6;
    localparam int L2_BITS    = E_BITS + 32;
    localparam int DIV_SHIFT  = TIME_FRAC_BITS + RATE_FRAC - 32;
    localparam int DIV_BITS   = L2_BITS + DIV_SHIFT;
    localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [TIME_BITS-1:0] CLOCK_MAX = '1;

    localparam logic [1:0] ST_FIRED   = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_RESTART = 2'd2;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_STEP    = 1'b1;

    localparam logic [2:0] CFG_RATE_ADSORB    = 3'd0;
    localparam logic [2:0] CFG_RATE_RECOMBINE = 3'd1;
    localparam logic [2:0] CFG_STOP_TIME      = 3'd2;
    localparam logic [2:0] CFG_START_FREE     = 3'd3;
    localparam logic [2:0] CFG_START_VACANT   = 3'd4;
    localparam logic [2:0] CFG_START_BOUND    = 3'd5;
    localparam logic [2:0] CFG_START_PAIRED   = 3'd6;

    typedef logic [COUNT_BITS-1:0] t_count;

    function automatic t_count inc_sat(input t_count v);
        inc_sat = (v == '1) ? v : v + t_count'(1);
    endfunction

endpackage
`default_nettype wire

// File: rtl/gts_mul.sv
// Digit-serial multiplier: one 8-bit digit of the multiplier per cycle, MSB digit first.
`timescale 1ns / 1ps
`default_nettype none
module gts_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [gts_pkg::MC_BITS-1:0] i_mcand,
    input  wire logic [gts_pkg::MP_BITS-1:0] i_mplier,
    output logic                             o_done,
    output logic [gts_pkg::ACC_BITS-1:0]     o_prod
);
    import gts_pkg::*;

    logic [MC_BITS-1:0]          r_mc;
    logic [MP_BITS-1:0]          r_mp;
    logic [ACC_BITS-1:0]         r_acc;
    logic [MCNT_BITS-1:0]        r_cnt;
    logic                        r_done;
    logic [MC_BITS+DIG_BITS-1:0] w_pp;
    logic [ACC_BITS-1:0]         n_acc;

    always_comb begin
        w_pp  = r_mc * r_mp[MP_BITS-1 -: DIG_BITS];
        n_acc = {r_acc[ACC_BITS-DIG_BITS-1:0], {DIG_BITS{1'b0}}}
              + ACC_BITS'(w_pp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mc  <= i_mcand;
                r_mp  <= i_mplier;
                r_acc <= '0;
                r_cnt <= MCNT_BITS'(MUL_DIGITS);
            end else if (r_cnt != '0) begin
                r_acc <= n_acc;
                r_mp  <= {r_mp[MP_BITS-DIG_BITS-1:0], {DIG_BITS{1'b0}}};
                r_cnt <= r_cnt - MCNT_BITS'(1);
                if (r_cnt == MCNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// File: rtl/gts_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gts_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gts_pkg::DIV_BITS-1:0]  i_dividend,
    input  wire logic [gts_pkg::PROP_BITS-1:0] i_divisor,
    output logic                               o_done,
    output logic [gts_pkg::DIV_BITS-1:0]       o_quot
);
    import gts_pkg::*;

    logic [DIV_BITS-1:0]  r_q;
    logic [PROP_BITS-1:0] r_rem;
    logic [PROP_BITS-1:0] r_d;
    logic [DCNT_BITS-1:0] r_cnt;
    logic                 r_done;
    logic [PROP_BITS:0]   w_trial;
    logic                 w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[DIV_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_dividend;
                r_d   <= i_divisor;
                r_rem <= '0;
                r_cnt <= DCNT_BITS'(DIV_BITS);
            end else if (r_cnt != '0) begin
                r_rem <= w_ge ? PROP_BITS'(w_trial - {1'b0, r_d}) : w_trial[PROP_BITS-1:0];
                r_q   <= {r_q[DIV_BITS-2:0], w_ge};
                r_cnt <= r_cnt - DCNT_BITS'(1);
                if (r_cnt == DCNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// File: rtl/gillespie_two_reaction_step.sv
// Top level: sequencer for one Gillespie direct-method step over two reactions.
// A restart or an early halt goes from the accept straight to the output register; a zero
// propensity halts after the propensity passes. A full step (fired or overshoot) takes 39
// multiplier passes (32 for the log2 squarings), a normalize loop and the divider.
// One item at a time; the next beat is taken the cycle after the result register loads.
// Synchronous active-low reset: counts and clock zero, halted, config at reset values.
`timescale 1ns / 1ps
`default_nettype none
module gillespie_two_reaction_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [63:0]   s_axis_tdata,  // wait_random[31:0], pick_random[63:32]
    input  wire logic [0:0]    s_axis_tuser,  // opcode[0]
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [111:0]       m_axis_tdata,  // time_now, free, vacant, bound, paired counts
    output logic [2:0]         m_axis_tuser   // status[1:0], which_reaction[2]
);
    import gts_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MA1  = 4'd1;
    localparam logic [3:0] S_MA2  = 4'd2;
    localparam logic [3:0] S_MB1  = 4'd3;
    localparam logic [3:0] S_MB2  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_NORM = 4'd7;
    localparam logic [3:0] S_SQ   = 4'd8;
    localparam logic [3:0] S_LNL  = 4'd9;
    localparam logic [3:0] S_LNH  = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]           r_state;
    logic                 r_go;
    logic                 r_dgo;
    logic [RATE_BITS-1:0] r_k1, r_k2;
    logic [TIME_BITS-1:0] r_stop;
    t_count               r_sfree, r_svac, r_sbound, r_spair;
    t_count               r_free, r_vacant, r_bound, r_paired;
    logic [TIME_BITS-1:0] r_clock;
    logic                 r_halted;
    logic [RAND_BITS-1:0] r_wrand, r_prand;
    logic [PROP_BITS-1:0] r_a, r_b, r_s;
    logic                 r_adsorb;
    logic [32:0]          r_y;
    logic [E_BITS-1:0]    r_e;
    logic [31:0]          r_f;
    logic [4:0]           r_sq_cnt;
    logic [L2_BITS-1:0]   r_n;
    logic [1:0]           r_status;
    logic                 r_which;
    logic                 r_ovalid;
    logic [111:0]         r_odata;
    logic [2:0]           r_ouser;

    logic [MC_BITS-1:0]   w_mc;
    logic [MP_BITS-1:0]   w_mp;
    logic                 w_mdone;
    logic [ACC_BITS-1:0]  w_prod;
    logic                 w_ddone;
    logic [DIV_BITS-1:0]  w_quot;
    logic [PROP_BITS:0]   w_sum;
    logic [L2_BITS-1:0]   w_l2;
    logic [32:0]          w_sq;
    logic [DIV_BITS:0]    w_tsum;
    logic [TIME_BITS-1:0] w_tnew;
    logic                 w_halt_now;

    always_comb begin
        unique case (r_state)
            S_MA1: begin
                w_mc = MC_BITS'(r_free);
                w_mp = MP_BITS'(r_vacant);
            end
            S_MA2: begin
                w_mc = r_a;
                w_mp = MP_BITS'(r_k1);
            end
            S_MB1: begin
                w_mc = MC_BITS'(r_free);
                w_mp = MP_BITS'(r_bound);
            end
            S_MB2: begin
                w_mc = r_b;
                w_mp = MP_BITS'(r_k2);
            end
            S_CMP: begin
                w_mc = r_s;
                w_mp = MP_BITS'(r_prand);
            end
            S_SQ: begin
                w_mc = MC_BITS'(r_y[31:0]);
                w_mp = MP_BITS'(r_y[31:0]);
            end
            S_LNL: begin
                w_mc = MC_BITS'(LN2_Q32);
                w_mp = MP_BITS'(w_l2[31:0]);
            end
            S_LNH: begin
                w_mc = MC_BITS'(LN2_Q32);
                w_mp = MP_BITS'(w_l2[L2_BITS-1:32]);
            end
            default: begin
                w_mc = '0;
                w_mp = '0;
            end
        endcase
    end

    always_comb begin
        w_sum      = {1'b0, r_a} + {1'b0, r_b};
        w_l2       = (L2_BITS'(RAND_BITS) << 32) - {r_e, r_f};
        w_sq       = w_prod[63:31];
        w_tsum     = (DIV_BITS+1)'(r_clock) + {1'b0, w_quot};
        w_tnew     = (w_tsum > (DIV_BITS+1)'(CLOCK_MAX)) ? CLOCK_MAX : w_tsum[TIME_BITS-1:0];
        w_halt_now = r_halted || (r_free == '0) || (r_vacant == '0) || (r_bound == '0)
                  || (r_paired == '0) || (r_clock >= r_stop);
    end

    gts_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_go),
        .i_mcand  (w_mc),
        .i_mplier (w_mp),
        .o_done   (w_mdone),
        .o_prod   (w_prod)
    );

    gts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend ({r_n, {DIV_SHIFT{1'b0}}}),
        .i_divisor  (r_s),
        .o_done     (w_ddone),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_dgo    <= 1'b0;
            r_k1     <= RATE_BITS'(32'd16777216);
            r_k2     <= RATE_BITS'(32'd16777216);
            r_stop   <= '0;
            r_sfree  <= '0;
            r_svac   <= '0;
            r_sbound <= '0;
            r_spair  <= '0;
            r_free   <= '0;
            r_vacant <= '0;
            r_bound  <= '0;
            r_paired <= '0;
            r_clock  <= '0;
            r_halted <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_go  <= 1'b0;
            r_dgo <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RATE_ADSORB:    r_k1     <= i_cfg_data[RATE_BITS-1:0];
                    CFG_RATE_RECOMBINE: r_k2     <= i_cfg_data[RATE_BITS-1:0];
                    CFG_STOP_TIME:      r_stop   <= i_cfg_data[TIME_BITS-1:0];
                    CFG_START_FREE:     r_sfree  <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_START_VACANT:   r_svac   <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_START_BOUND:    r_sbound <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_START_PAIRED:   r_spair  <= i_cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_wrand <= s_axis_tdata[RAND_BITS-1:0];
                        r_prand <= s_axis_tdata[32 +: RAND_BITS];
                        r_which <= 1'b0;
                        r_state <= S_DONE;
                        if (s_axis_tuser[0] == OP_RESTART) begin
                            r_free   <= r_sfree;
                            r_vacant <= r_svac;
                            r_bound  <= r_sbound;
                            r_paired <= r_spair;
                            r_clock  <= '0;
                            r_halted <= 1'b0;
                            r_status <= ST_RESTART;
                        end else if (w_halt_now) begin
                            r_halted <= 1'b1;
                            r_status <= ST_HALT;
                        end else begin
                            r_state <= S_MA1;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_MA1: begin
                    if (w_mdone) begin
                        r_a     <= w_prod[PROP_BITS-1:0];
                        r_state <= S_MA2;
                        r_go    <= 1'b1;
                    end
                end
                S_MA2: begin
                    if (w_mdone) begin
                        r_a     <= w_prod[PROP_BITS-1:0];
                        r_state <= S_MB1;
                        r_go    <= 1'b1;
                    end
                end
                S_MB1: begin
                    if (w_mdone) begin
                        r_b     <= w_prod[PROP_BITS-1:0];
                        r_state <= S_MB2;
                        r_go    <= 1'b1;
                    end
                end
                S_MB2: begin
                    if (w_mdone) begin
                        r_b     <= w_prod[PROP_BITS-1:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if ((r_a == '0) || (r_b == '0)) begin
                        r_halted <= 1'b1;
                        r_status <= ST_HALT;
                        r_state  <= S_DONE;
                    end else begin
                        r_s     <= w_sum[PROP_BITS] ? '1 : w_sum[PROP_BITS-1:0];
                        r_state <= S_CMP;
                        r_go    <= 1'b1;
                    end
                end
                S_CMP: begin
                    if (w_mdone) begin
                        r_adsorb <= (w_prod[PROP_BITS+RAND_BITS-1:0] < {r_a, {RAND_BITS{1'b0}}});
                        r_y      <= {1'b0, r_wrand} + 33'd1;
                        r_e      <= E_BITS'(32);
                        r_state  <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_y[32]) begin
                        r_y      <= {1'b0, r_y[32:1]};
                        r_f      <= '0;
                        r_sq_cnt <= '0;
                        r_state  <= S_SQ;
                        r_go     <= 1'b1;
                    end else begin
                        r_y <= {r_y[31:0], 1'b0};
                        r_e <= r_e - E_BITS'(1);
                    end
                end
                S_SQ: begin
                    if (w_mdone) begin
                        r_f      <= {r_f[30:0], w_sq[32]};
                        r_y      <= {1'b0, w_sq[32] ? w_sq[32:1] : w_sq[31:0]};
                        r_sq_cnt <= r_sq_cnt + 5'd1;
                        r_go     <= 1'b1;
                        if (r_sq_cnt == '1) begin
                            r_state <= S_LNL;
                        end
                    end
                end
                S_LNL: begin
                    if (w_mdone) begin
                        r_n     <= L2_BITS'(w_prod[63:32]);
                        r_state <= S_LNH;
                        r_go    <= 1'b1;
                    end
                end
                S_LNH: begin
                    if (w_mdone) begin
                        r_n     <= r_n + w_prod[L2_BITS-1:0];
                        r_state <= S_DIV;
                        r_dgo   <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_state <= S_DONE;
                        if (w_tnew > r_stop) begin
                            r_halted <= 1'b1;
                            r_status <= ST_HALT;
                        end else begin
                            r_clock  <= w_tnew;
                            r_status <= ST_FIRED;
                            r_which  <= !r_adsorb;
                            r_free   <= r_free - t_count'(1);
                            if (r_adsorb) begin
                                r_vacant <= r_vacant - t_count'(1);
                                r_bound  <= inc_sat(r_bound);
                            end else begin
                                r_bound  <= r_bound - t_count'(1);
                                r_paired <= inc_sat(r_paired);
                                r_vacant <= inc_sat(r_vacant);
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {r_paired, r_bound, r_vacant, r_free, r_clock};
                        r_ouser  <= {r_which, r_status};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
`default_nettype wire

// File: rtl/gts_chk.sv
// Port-level checker for the Gillespie stepper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gts_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata,
    input wire logic [2:0]   m_axis_tuser
);
    import gts_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again before result");

    a_restart_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == ST_RESTART) |-> (m_axis_tdata[47:0] == '0))
        else $error("restart beat with nonzero time");

    a_which: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != ST_FIRED) |-> !m_axis_tuser[2])
        else $error("reaction flagged without firing");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind gillespie_two_reaction_step gts_chk u_gts_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
